// ----- hdl/spq_pkg.sv -----
// shared types and constants for the stable priority task queue
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ID_W  = 8;
	localparam int PRI_W = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_START  = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOSTART = 2'd2,
		ST_NORUN   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage

// ----- hdl/spq_dp.sv -----
// datapath: sorted entry row, compare masks, update and result register
module spq_dp import spq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [1:0]        opcode,
	input  logic [ID_W-1:0]   task_id,
	input  logic [PRI_W-1:0]  task_priority,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   started_id,
	output logic [CNT_W-1:0]  occupancy
);

	// entry row and count
	logic [ID_W-1:0]  ids_q  [DEPTH];
	logic [PRI_W-1:0] prio_q [DEPTH];
	logic [DEPTH-1:0] run_q;
	logic [CNT_W-1:0] cnt_q;

	// captured item and masks
	op_t              op_s1;
	logic [ID_W-1:0]  id_s1;
	logic [PRI_W-1:0] prio_s1;
	logic [DEPTH-1:0] le_s1;
	logic [DEPTH-1:0] rm_s1;

	// result register
	status_t          status_q;
	logic [ID_W-1:0]  started_q;
	logic [CNT_W-1:0] occ_q;

	logic [DEPTH-1:0] valid;
	logic [DEPTH-1:0] le;
	logic [DEPTH-1:0] rm;
	logic [DEPTH-1:0] le_prev;
	logic [DEPTH-1:0] rm_prev;
	logic [DEPTH-1:0] fin_sel;
	logic [ID_W-1:0]  ids_up  [DEPTH];
	logic [ID_W-1:0]  ids_dn  [DEPTH];
	logic [PRI_W-1:0] prio_up [DEPTH];
	logic [PRI_W-1:0] prio_dn [DEPTH];
	logic [DEPTH-1:0] run_up;
	logic [DEPTH-1:0] run_dn;
	logic [ID_W-1:0]  fin_id;

	logic [ID_W-1:0]  ids_d  [DEPTH];
	logic [PRI_W-1:0] prio_d [DEPTH];
	logic [DEPTH-1:0] run_d;
	logic [CNT_W-1:0] cnt_d;
	status_t          status_d;
	logic [ID_W-1:0]  started_d;

	// per-entry compares against the incoming priority and running prefix
	always_comb begin
		logic acc;
		acc = 1'b0;
		for (int k = 0; k < DEPTH; k++) begin
			valid[k] = (CNT_W'(k) < cnt_q);
			le[k]    = valid[k] && (prio_q[k] <= task_priority);
			acc      = acc | (valid[k] & run_q[k]);
			rm[k]    = acc;
		end
	end

	// neighbour views of the row for shifting
	always_comb begin
		ids_up[0]        = id_s1;
		prio_up[0]       = prio_s1;
		ids_dn[DEPTH-1]  = '0;
		prio_dn[DEPTH-1] = '0;
		for (int k = 1; k < DEPTH; k++) begin
			ids_up[k]  = ids_q[k-1];
			prio_up[k] = prio_q[k-1];
		end
		for (int k = 0; k < DEPTH - 1; k++) begin
			ids_dn[k]  = ids_q[k+1];
			prio_dn[k] = prio_q[k+1];
		end
		run_up  = {run_q[DEPTH-2:0], 1'b0};
		run_dn  = {1'b0, run_q[DEPTH-1:1]};
		le_prev = {le_s1[DEPTH-2:0], 1'b1};
		rm_prev = {rm_s1[DEPTH-2:0], 1'b0};
		fin_sel = rm_s1 & ~rm_prev;
	end

	// id of the first running entry
	always_comb begin
		fin_id = '0;
		for (int k = 0; k < DEPTH; k++) begin
			fin_id = fin_id | (fin_sel[k] ? ids_q[k] : '0);
		end
	end

	// next row state and result
	always_comb begin
		ids_d     = ids_q;
		prio_d    = prio_q;
		run_d     = run_q;
		cnt_d     = cnt_q;
		status_d  = ST_OK;
		started_d = '0;
		case (op_s1)
			OP_INSERT: begin
				if (cnt_q == CNT_W'(DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					for (int k = 0; k < DEPTH; k++) begin
						if (!le_s1[k]) begin
							if (le_prev[k]) begin
								ids_d[k]  = id_s1;
								prio_d[k] = prio_s1;
								run_d[k]  = 1'b0;
							end else begin
								ids_d[k]  = ids_up[k];
								prio_d[k] = prio_up[k];
								run_d[k]  = run_up[k];
							end
						end
					end
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			OP_START: begin
				if (cnt_q == '0 || run_q[0]) begin
					status_d = ST_NOSTART;
				end else begin
					run_d[0]  = 1'b1;
					started_d = ids_q[0];
				end
			end
			OP_FINISH: begin
				if (!rm_s1[DEPTH-1]) begin
					status_d = ST_NORUN;
				end else begin
					for (int k = 0; k < DEPTH; k++) begin
						if (rm_s1[k]) begin
							ids_d[k]  = ids_dn[k];
							prio_d[k] = prio_dn[k];
							run_d[k]  = run_dn[k];
						end
					end
					cnt_d     = cnt_q - CNT_W'(1);
					started_d = fin_id;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// control state of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			cnt_q <= '0;
		end else if (cmd.commit) begin
			run_q <= run_d;
			cnt_q <= cnt_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1   <= op_t'(opcode);
			id_s1   <= task_id;
			prio_s1 <= task_priority;
			le_s1   <= le;
			rm_s1   <= rm;
		end
		if (cmd.commit) begin
			ids_q     <= ids_d;
			prio_q    <= prio_d;
			status_q  <= status_d;
			started_q <= started_d;
			occ_q     <= cnt_d;
		end
	end

	assign status     = status_q;
	assign started_id = started_q;
	assign occupancy  = occ_q;

endmodule

// ----- hdl/spq_ctrl.sv -----
// controller: capture and commit sequencing plus output valid
module spq_ctrl import spq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   room;

	// output register free now or at this edge
	assign room = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && room) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = room;
				cmd.capture = in_valid && room;
			end
			S_EXEC: begin
				cmd.commit = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/stable_priority_task_queue.sv -----
// top level of the stable priority task queue
//
//  channel | signals                                    | handshake
//  in      | opcode, task_id, task_priority             | in_valid / in_ready
//  out     | status, started_id, occupancy              | out_valid / out_ready
//
// each item is handled as a capture of the item and the entry compare masks,
// then a commit step that shifts the entry row and loads the result register.
// a new item is taken while the previous result waits, as long as the result
// register frees by that edge. reset clears the count and running bits;
// entry payloads are only read below the count. no clearing pass is needed.
module stable_priority_task_queue import spq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [ID_W-1:0]   task_id,
	input  logic [PRI_W-1:0]  task_priority,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   started_id,
	output logic [CNT_W-1:0]  occupancy
);

	dp_cmd_t cmd;

	// sequencing
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// entry row and result
	spq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (opcode),
		.task_id       (task_id),
		.task_priority (task_priority),
		.status        (status),
		.started_id    (started_id),
		.occupancy     (occupancy)
	);

	// an accepted item is followed by the busy commit state, with in_ready low
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted during commit cycle");

	// every accepted item yields a valid result once its commit is done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("result missing after item");

	// occupancy never exceeds the queue depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= CNT_W'(DEPTH))
		else $error("occupancy beyond depth");

	// failed operations report a zero id
	a_fail_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> started_id == '0)
		else $error("non-zero id on failed operation");

endmodule

// ----- sim/spq_checker.sv -----
// checker for the stable priority task queue: shadow queue model and result compare
module spq_checker import spq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [1:0]       opcode,
	input  logic [ID_W-1:0]  task_id,
	input  logic [PRI_W-1:0] task_priority,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [1:0]       status,
	input  logic [ID_W-1:0]  started_id,
	input  logic [CNT_W-1:0] occupancy,
	output int               errors,
	output int               outstanding,
	output int               checked
);

	typedef struct packed {
		status_t          st;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] occ;
	} task_result_t;

	// shadow copy of the sorted entry row
	logic [ID_W-1:0]  shadow_id  [DEPTH];
	logic [PRI_W-1:0] shadow_pri [DEPTH];
	logic             shadow_run [DEPTH];
	int               shadow_len;

	task_result_t pending_results [$];
	int           err_cnt;
	int           chk_cnt;

	// applies one item to the shadow queue and returns the result it should give
	function automatic task_result_t apply_task_op(logic [1:0] op, logic [ID_W-1:0] id,
			logic [PRI_W-1:0] pri);
		task_result_t r;
		int           pos;
		int           k;
		r.st = ST_OK;
		r.id = '0;
		pos  = 0;
		case (op)
			OP_INSERT: begin
				if (shadow_len >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					// new entry goes after every entry of equal or smaller priority
					while (pos < shadow_len && shadow_pri[pos] <= pri)
						pos++;
					for (k = shadow_len; k > pos; k--) begin
						shadow_id[k]  = shadow_id[k-1];
						shadow_pri[k] = shadow_pri[k-1];
						shadow_run[k] = shadow_run[k-1];
					end
					shadow_id[pos]  = id;
					shadow_pri[pos] = pri;
					shadow_run[pos] = 1'b0;
					shadow_len++;
				end
			end
			OP_START: begin
				if (shadow_len == 0 || shadow_run[0]) begin
					r.st = ST_NOSTART;
				end else begin
					shadow_run[0] = 1'b1;
					r.id = shadow_id[0];
				end
			end
			OP_FINISH: begin
				// first running entry in queue order is the latest started
				while (pos < shadow_len && !shadow_run[pos])
					pos++;
				if (pos >= shadow_len) begin
					r.st = ST_NORUN;
				end else begin
					r.id = shadow_id[pos];
					for (k = pos; k + 1 < shadow_len; k++) begin
						shadow_id[k]  = shadow_id[k+1];
						shadow_pri[k] = shadow_pri[k+1];
						shadow_run[k] = shadow_run[k+1];
					end
					shadow_len--;
					shadow_run[shadow_len] = 1'b0;
				end
			end
			default: begin
				// unused opcode leaves the queue alone
			end
		endcase
		r.occ = CNT_W'(shadow_len);
		return r;
	endfunction

	// results first, since a result never belongs to an item taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		task_result_t exp;
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++)
				shadow_run[k] = 1'b0;
			shadow_len = 0;
			pending_results.delete();
			err_cnt = 0;
			chk_cnt = 0;
			errors      <= 0;
			outstanding <= 0;
			checked     <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, actual status %0d id %0d occupancy %0d",
						$time, status, started_id, occupancy);
				end else begin
					exp = pending_results.pop_front();
					chk_cnt++;
					if (status !== exp.st) begin
						err_cnt++;
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, exp.st, status);
					end
					if (started_id !== exp.id) begin
						err_cnt++;
						$display("%0t: started_id mismatch, expected %0d, actual %0d",
							$time, exp.id, started_id);
					end
					if (occupancy !== exp.occ) begin
						err_cnt++;
						$display("%0t: occupancy mismatch, expected %0d, actual %0d",
							$time, exp.occ, occupancy);
					end
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(apply_task_op(opcode, task_id, task_priority));
			errors      <= err_cnt;
			outstanding <= pending_results.size();
			checked     <= chk_cnt;
		end
	end

endmodule

// ----- sim/testbench.sv -----
// testbench top for the stable priority task queue: stimulus, idling and verdict
module testbench import spq_pkg::*;;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         HOLD_CYCLES = 300;
	localparam int         PHASE_ITEMS = 275;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       opcode;
	logic [ID_W-1:0]  task_id;
	logic [PRI_W-1:0] task_priority;
	logic             out_valid;
	logic             out_ready;
	logic [1:0]       status;
	logic [ID_W-1:0]  started_id;
	logic [CNT_W-1:0] occupancy;

	int errors;
	int outstanding;
	int checked;
	int tx_idle_pct;
	int rx_stall_pct;
	int hold_req;
	int items_sent;
	int cycle_count;
	bit fill_mode;

	stable_priority_task_queue u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.task_id       (task_id),
		.task_priority (task_priority),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.started_id    (started_id),
		.occupancy     (occupancy)
	);

	spq_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.task_id       (task_id),
		.task_priority (task_priority),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.started_id    (started_id),
		.occupancy     (occupancy),
		.errors        (errors),
		.outstanding   (outstanding),
		.checked       (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// output side: random stalls, plus a long hold whenever one is requested
	initial begin
		int hold_seen;
		hold_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// offers one item, holds it until taken, then maybe drops valid for a gap
	task automatic send_item(logic [1:0] op, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
		in_valid      <= 1'b1;
		opcode        <= op;
		task_id       <= id;
		task_priority <= pri;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct)
				@(posedge clk);
		end
	endtask

	// fill and drain episodes so the queue swings between empty and full
	task automatic send_random();
		logic [1:0]       op;
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
		int               roll;
		if ($urandom_range(39) == 0)
			fill_mode = !fill_mode;
		roll = $urandom_range(99);
		if (fill_mode)
			op = roll < 60 ? OP_INSERT : roll < 78 ? OP_START : roll < 95 ? OP_FINISH : OP_UNUSED;
		else
			op = roll < 15 ? OP_INSERT : roll < 50 ? OP_START : roll < 95 ? OP_FINISH : OP_UNUSED;
		id = ID_W'($urandom_range(255));
		// narrow priorities half the time to get plenty of ties
		pri = $urandom_range(1) ? PRI_W'($urandom_range(3)) : PRI_W'($urandom_range(255));
		send_item(op, id, pri);
	endtask

	initial begin
		int k;
		int ph;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		opcode        = OP_INSERT;
		task_id       = '0;
		task_priority = '0;
		tx_idle_pct   = 0;
		rx_stall_pct  = 0;
		hold_req      = 0;
		items_sent    = 0;
		cycle_count   = 0;
		fill_mode     = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue cases
		send_item(OP_FINISH, 8'h00, 8'h00);
		send_item(OP_START, 8'hff, 8'hff);
		// extremes, running head, insert ahead of a running head
		send_item(OP_INSERT, 8'hff, 8'hff);
		send_item(OP_START, 8'h00, 8'h00);
		send_item(OP_START, 8'h00, 8'h00);
		send_item(OP_INSERT, 8'h00, 8'h00);
		send_item(OP_START, 8'h00, 8'h00);
		send_item(OP_FINISH, 8'h00, 8'h00);
		send_item(OP_FINISH, 8'h00, 8'h00);
		// fill with repeating priorities, then insert when full and the unused opcode
		for (k = 0; k < DEPTH; k++)
			send_item(OP_INSERT, ID_W'(k * 17), PRI_W'(k % 4));
		send_item(OP_INSERT, 8'ha5, 8'h00);
		send_item(OP_UNUSED, 8'h5a, 8'hff);

		// random part in four idling phases, the first opening with a long hold
		for (ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = (ph == 1) ? 76 : (ph == 3) ? 28 : 0;
			rx_stall_pct = (ph == 2) ? 76 : (ph == 3) ? 28 : 0;
			if (ph == 0)
				hold_req++;
			for (k = 0; k < PHASE_ITEMS; k++)
				send_random();
		end

		// drain
		in_valid     <= 1'b0;
		rx_stall_pct = 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("summary: %0d items sent across four idling phases and a long output hold",
			items_sent);
		$display("summary: %0d results compared, incl. full, empty, ties and running head cases",
			checked);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
